/* hw/rtl/tcw_pkg.sv */
package tcw_pkg;

   // screen geometry
   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = ROWS * COLUMNS;

   localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int ADDR_W = $clog2(CELLS);

   // field widths on the stream ports
   localparam int CHAR_W      = 8;
   localparam int RROW_W      = 5;
   localparam int RCOL_W      = 7;
   localparam int CELL_W      = 16;
   localparam int ATTR_W      = 8;
   localparam int REQ_DATA_W  = 24;
   localparam int RSP_DATA_W  = 32;

   // character codes
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_SPACE = 8'd32;

   // item kinds
   localparam logic KIND_PUT  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   // cell values
   localparam logic [CELL_W-1:0] RESET_CELL  = 16'h0720;
   localparam logic [CELL_W-1:0] SCROLL_FILL = 16'h0020;
   localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h07;

endpackage

/* hw/rtl/text_console_writer.sv */
// text_console_writer: character console over a ROWS x COLUMNS cell store.
// Requests pass S_ADDR, S_EXEC, S_RESP; a new one is taken only after the last is done.
// A put that advances past the last row scrolls, and S_SCROLL clears the freed row.
// Scroll moves a top-row pointer; the shared address unit (row wrap, multiply-add)
// serves reads, writes and the row clear. Synchronous active-high reset; afterwards a
// clearing pass over all ROWS*COLUMNS cells fills the store with 0x0720, req_tready low.
module text_console_writer (
   input  logic        clock,
   input  logic        reset,
   // request: tdata = char_code[7:0], read_row[12:8], read_col[19:13], zero pad [23:20]
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,
   input  logic [0:0]  req_tuser,   // kind[0]: 0 put, 1 read
   // response: tdata = cell_value[15:0], cursor_row[20:16], cursor_col[27:21], pad [31:28]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   // attribute register write
   input  logic        csr_tvalid,
   output logic        csr_tready,
   input  logic [7:0]  csr_tdata    // text_attribute[7:0]
);

   localparam int COL_W  = tcw_pkg::COL_W;
   localparam int ROW_W  = tcw_pkg::ROW_W;
   localparam int ADDR_W = tcw_pkg::ADDR_W;

   // sequencer states
   localparam logic [2:0] S_CLEAR  = 3'd0;  // reset sweep over the whole store
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ADDR   = 3'd2;  // address unit result into addr_ff
   localparam logic [2:0] S_EXEC   = 3'd3;  // memory access, cursor update
   localparam logic [2:0] S_SCROLL = 3'd4;  // fill the freed row
   localparam logic [2:0] S_RESP   = 3'd5;  // hand result to output register

   logic [2:0]                  state_ff, state_in;
   logic [ROW_W-1:0]            row_ff, row_in;      // cursor row
   logic [COL_W-1:0]            col_ff, col_in;      // cursor column
   logic [ROW_W-1:0]            top_ff, top_in;      // physical row shown as row 0
   logic [ADDR_W-1:0]           cnt_ff, cnt_in;      // sweep counter
   logic [tcw_pkg::ATTR_W-1:0]  attr_ff, attr_in;

   // latched request
   logic                        kind_ff, kind_in;
   logic [tcw_pkg::CHAR_W-1:0]  code_ff, code_in;
   logic [tcw_pkg::RROW_W-1:0]  rrow_ff, rrow_in;
   logic [tcw_pkg::RCOL_W-1:0]  rcol_ff, rcol_in;
   logic                        rd_ok_ff, rd_ok_in;  // read and inside the store

   logic [ADDR_W-1:0]           addr_ff, addr_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // memory
   logic [tcw_pkg::CELL_W-1:0]  mem [tcw_pkg::CELLS];
   logic [tcw_pkg::CELL_W-1:0]  rd_data_ff;
   logic                        mem_we;
   logic [ADDR_W-1:0]           mem_wa;
   logic [tcw_pkg::CELL_W-1:0]  mem_wd;

   // shared address unit: logical row/col -> flat address through the top pointer
   logic [ROW_W-1:0]            au_row;
   logic [COL_W-1:0]            au_col;
   logic [ROW_W:0]              au_sum;
   logic [ROW_W-1:0]            au_phys;
   logic [ADDR_W-1:0]           au_addr;

   logic                        req_xfer;
   logic                        col_wrap;
   logic                        last_row;

   assign req_tready = (state_ff == S_IDLE);
   assign req_xfer   = req_tvalid && req_tready;
   assign csr_tready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      if (state_ff == S_SCROLL) begin
         au_row = ROW_W'(tcw_pkg::ROWS - 1);
         au_col = cnt_ff[COL_W-1:0];
      end else if (kind_ff == tcw_pkg::KIND_READ) begin
         au_row = ROW_W'(rrow_ff);
         au_col = COL_W'(rcol_ff);
      end else begin
         au_row = row_ff;
         au_col = col_ff;
      end
      au_sum = {1'b0, au_row} + {1'b0, top_ff};
      if (32'(au_sum) >= tcw_pkg::ROWS) begin
         au_phys = ROW_W'(32'(au_sum) - tcw_pkg::ROWS);
      end else begin
         au_phys = au_sum[ROW_W-1:0];
      end
      au_addr = ADDR_W'(32'(au_phys) * tcw_pkg::COLUMNS + 32'(au_col));
   end

   assign col_wrap = (32'(col_ff) + 1 >= tcw_pkg::COLUMNS);
   assign last_row = (32'(row_ff) + 1 >= tcw_pkg::ROWS);

   always_comb begin
      state_in     = state_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      top_in       = top_ff;
      cnt_in       = cnt_ff;
      attr_in      = attr_ff;
      kind_in      = kind_ff;
      code_in      = code_ff;
      rrow_in      = rrow_ff;
      rcol_in      = rcol_ff;
      rd_ok_in     = rd_ok_ff;
      addr_in      = addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = tcw_pkg::RESET_CELL;

      if (csr_tvalid && csr_tready) begin
         attr_in = csr_tdata;
      end
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = cnt_ff;
            mem_wd = tcw_pkg::RESET_CELL;
            if (32'(cnt_ff) == tcw_pkg::CELLS - 1) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               kind_in  = req_tuser[0];
               code_in  = req_tdata[7:0];
               rrow_in  = req_tdata[12:8];
               rcol_in  = req_tdata[19:13];
               rd_ok_in = (req_tuser[0] == tcw_pkg::KIND_READ)
                          && (32'(req_tdata[12:8]) < tcw_pkg::ROWS)
                          && (32'(req_tdata[19:13]) < tcw_pkg::COLUMNS);
               state_in = S_ADDR;
            end
         end
         S_ADDR: begin
            addr_in  = au_addr;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            // reads fetch mem[addr_ff] this cycle; data lands in rd_data_ff
            state_in = S_RESP;
            if (kind_ff == tcw_pkg::KIND_PUT) begin
               if (code_ff == tcw_pkg::CODE_CR) begin
                  col_in = '0;
               end else if (code_ff == tcw_pkg::CODE_LF) begin
                  col_in = '0;
                  if (last_row) begin
                     state_in = S_SCROLL;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  mem_we = 1'b1;
                  mem_wa = addr_ff;
                  mem_wd = {attr_ff, code_ff};
                  if (col_wrap) begin
                     col_in = '0;
                     if (last_row) begin
                        state_in = S_SCROLL;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end else begin
                     col_in = col_ff + 1'b1;
                  end
               end
               if (state_in == S_SCROLL) begin
                  // oldest row becomes the bottom row; cursor row stays put
                  cnt_in = '0;
                  if (32'(top_ff) + 1 >= tcw_pkg::ROWS) begin
                     top_in = '0;
                  end else begin
                     top_in = top_ff + 1'b1;
                  end
               end
            end
         end
         S_SCROLL: begin
            mem_we = 1'b1;
            mem_wa = au_addr;
            mem_wd = tcw_pkg::SCROLL_FILL;
            if (32'(cnt_ff) == tcw_pkg::COLUMNS - 1) begin
               cnt_in   = '0;
               state_in = S_RESP;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, tcw_pkg::RCOL_W'(col_ff), tcw_pkg::RROW_W'(row_ff),
                               rd_ok_ff ? rd_data_ff : 16'h0000};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         row_ff       <= '0;
         col_ff       <= '0;
         top_ff       <= '0;
         cnt_ff       <= '0;
         attr_ff      <= tcw_pkg::ATTR_RESET;
         kind_ff      <= tcw_pkg::KIND_PUT;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         top_ff       <= top_in;
         cnt_ff       <= cnt_in;
         attr_ff      <= attr_in;
         kind_ff      <= kind_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      code_ff     <= code_in;
      rrow_ff     <= rrow_in;
      rcol_ff     <= rcol_in;
      addr_ff     <= addr_in;
      rsp_data_ff <= rsp_data_in;
   end

   // cell store: one write port, registered read at addr_ff
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem[addr_ff];
   end

endmodule

/* hw/rtl/tcw_checker.sv */
module tcw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [23:0] req_tdata,
   input logic [0:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        csr_tvalid,
   input logic        csr_tready,
   input logic [7:0]  csr_tdata
);

   // one item at a time: ready drops right after a request transfer
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // clearing pass keeps requests off right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("ready during reset clear");

   // cursor column and row in range
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (32'(rsp_tdata[27:21]) < tcw_pkg::COLUMNS)
                     && (32'(rsp_tdata[20:16]) < tcw_pkg::ROWS))
      else $error("cursor out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("stalled response changed");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);

/* dv/text_console_writer_tb.sv */
module text_console_writer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tcw_pkg::*;

   // The limit covers the clearing pass plus, for each of about 1550 items, its own
   // states, a scroll, the longest receiver stall and the longest sender gap, with a
   // wide margin.
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 255;
   localparam int PHASES      = 6;

   // one response beat, split into its fields
   typedef struct packed {
      logic [CELL_W-1:0] cell_word;
      logic [RROW_W-1:0] row;
      logic [RCOL_W-1:0] col;
   } console_view_type;

   // Shadow copy of the console: the cell store, the cursor and the attribute.
   // Each accepted request is applied here, and the view that the block must
   // return is queued until the response transfer arrives.
   class console_shadow;
      logic [CELL_W-1:0] cells [CELLS];
      int unsigned       row_pos;
      int unsigned       col_pos;
      logic [ATTR_W-1:0] attribute;
      console_view_type  awaited_views [$];
      int unsigned       mismatches;

      function new();
         foreach (cells[i]) cells[i] = RESET_CELL;
         row_pos     = 0;
         col_pos     = 0;
         attribute   = ATTR_RESET;
         mismatches  = 0;
      endfunction

      function void set_attribute(logic [ATTR_W-1:0] value);
         attribute = value;
      endfunction

      // Moving down from the bottom row scrolls the screen up one row. The
      // new bottom row is filled with blanks on a black attribute.
      function void next_line();
         if (row_pos + 1 >= ROWS) begin
            for (int i = 0; i + COLUMNS < CELLS; i++) cells[i] = cells[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = SCROLL_FILL;
            row_pos = ROWS - 1;
         end else begin
            row_pos++;
         end
      endfunction

      function void print_byte(logic [CHAR_W-1:0] code);
         if (code == CODE_CR) begin
            col_pos = 0;
         end else if (code == CODE_LF) begin
            col_pos = 0;
            next_line();
         end else begin
            cells[row_pos * COLUMNS + col_pos] = {attribute, code};
            col_pos++;
            if (col_pos >= COLUMNS) begin
               col_pos = 0;
               next_line();
            end
         end
      endfunction

      function void note_request(logic kind, logic [CHAR_W-1:0] code,
                                 logic [RROW_W-1:0] rrow, logic [RCOL_W-1:0] rcol);
         console_view_type view;
         view.cell_word = '0;
         if (kind == KIND_PUT) begin
            print_byte(code);
         end else if (rrow < ROWS && rcol < COLUMNS) begin
            view.cell_word = cells[rrow * COLUMNS + rcol];
         end
         view.row = row_pos[RROW_W-1:0];
         view.col = col_pos[RCOL_W-1:0];
         awaited_views.push_back(view);
      endfunction

      function void check_response(logic [RSP_DATA_W-1:0] word);
         console_view_type want;
         console_view_type got;
         got.cell_word = word[15:0];
         got.row       = word[20:16];
         got.col       = word[27:21];
         if (awaited_views.size() == 0) begin
            $display("%0t: response with nothing expected: cell %h row %0d col %0d",
                     $time, got.cell_word, got.row, got.col);
            mismatches++;
            return;
         end
         want = awaited_views.pop_front();
         if (got.cell_word !== want.cell_word) begin
            $display("%0t: cell_value expected %h actual %h", $time, want.cell_word,
                     got.cell_word);
            mismatches++;
         end
         if (got.row !== want.row) begin
            $display("%0t: cursor_row expected %0d actual %0d", $time, want.row, got.row);
            mismatches++;
         end
         if (got.col !== want.col) begin
            $display("%0t: cursor_col expected %0d actual %0d", $time, want.col, got.col);
            mismatches++;
         end
      endfunction

      function int pending();
         return awaited_views.size();
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [0:0]            req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_tvalid = 1'b0;
   logic                  csr_tready;
   logic [ATTR_W-1:0]     csr_tdata  = '0;

   console_shadow shadow = new();
   int unsigned   cycle_count = 0;
   int unsigned   burst_left  = 0;

   // receiver stall pattern state
   int unsigned   stall_left  = 0;
   int unsigned   stall_pct   = 0;
   int unsigned   stall_max   = 1;

   text_console_writer uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // char_code, read_row, read_col, zero pad
      .req_tuser  (req_tuser),   // kind
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // cell_value, cursor_row, cursor_col, pad
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)    // text_attribute
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Timeout. It also covers a block that never leaves its clearing pass.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Response transfers are checked at the rising edge. rsp_tready only
   // changes on the falling edge, so what is seen here is stable.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) shadow.check_response(rsp_tdata);
   end

   // Receiver back-pressure. The bench switches between modes: always ready, sparse
   // short stalls, medium ones, or frequent long ones, so that stalls land on each
   // phase of the block's work, scrolls included.
   always @(negedge clock) begin
      if (cycle_count % 300 == 0) begin
         case ($urandom_range(3))
            0: begin stall_pct = 0;  stall_max = 1;  end
            1: begin stall_pct = 10; stall_max = 4;  end
            2: begin stall_pct = 40; stall_max = 8;  end
            default: begin stall_pct = 70; stall_max = 30; end
         endcase
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(99) < stall_pct) stall_left = $urandom_range(stall_max, 1);
      end
   end

   // One request transfer. The sender works in bursts: when a burst runs out,
   // tvalid drops for a random gap, or for none, and a new burst length is drawn.
   // Within a burst tvalid stays high and only the payload changes.
   task automatic send_request(logic kind, logic [CHAR_W-1:0] code,
                               logic [RROW_W-1:0] rrow, logic [RCOL_W-1:0] rcol);
      int unsigned gap;
      if (burst_left == 0) begin
         gap        = ($urandom_range(99) < 30) ? 0 : $urandom_range(6, 1);
         burst_left = $urandom_range(24, 1);
         if (gap != 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {4'b0000, rcol, rrow, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      shadow.note_request(kind, code, rrow, rcol);
   endtask

   // Drop tvalid right after the last transfer so that nothing is taken twice.
   // Then wait until every response is in.
   task automatic settle_console();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (shadow.pending() != 0) @(posedge clock);
   endtask

   // Attribute write. It is done only while the console is idle.
   task automatic write_attribute(logic [ATTR_W-1:0] value);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata  <= value;
      @(posedge clock);
      while (!csr_tready) @(posedge clock);
      shadow.set_attribute(value);
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   // Random request. Puts carry text with plenty of line feeds, so the screen
   // fills and scrolls often. Reads mostly look at cells in range, often on the
   // cursor row where recent text sits. Some reads use the full field range,
   // out-of-range positions included.
   task automatic random_request();
      logic              kind;
      logic [CHAR_W-1:0] code;
      logic [RROW_W-1:0] rrow;
      logic [RCOL_W-1:0] rcol;
      int unsigned       pick;
      kind = ($urandom_range(99) < 30) ? KIND_READ : KIND_PUT;
      code = CHAR_W'($urandom_range(255));
      rrow = RROW_W'($urandom_range(31));
      rcol = RCOL_W'($urandom_range(127));
      pick = $urandom_range(99);
      if (kind == KIND_PUT) begin
         if (pick < 12) code = CODE_LF;
         else if (pick < 17) code = CODE_CR;
         else if (pick < 60) code = CHAR_W'($urandom_range(126, 32));
      end else begin
         if (pick < 50) begin
            rrow = RROW_W'($urandom_range(ROWS - 1));
            rcol = RCOL_W'($urandom_range(COLUMNS - 1));
         end else if (pick < 80) begin
            rrow = shadow.row_pos[RROW_W-1:0];
            rcol = RCOL_W'($urandom_range(COLUMNS - 1));
         end
      end
      send_request(kind, code, rrow, rcol);
   endtask

   initial begin
      logic [ATTR_W-1:0] phase_attr [PHASES];
      phase_attr[0] = 8'h00;
      phase_attr[1] = 8'h1E;
      phase_attr[2] = ATTR_W'($urandom_range(255));
      phase_attr[3] = 8'hFF;
      phase_attr[4] = 8'hF0;
      phase_attr[5] = ATTR_W'($urandom_range(255));

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, on the reset attribute. The first reads are of cleared
      // cells at the corners, then of positions past the last row and column.
      send_request(KIND_READ, 8'h00, 5'd0, 7'd0);
      send_request(KIND_READ, 8'h00, 5'd24, 7'd79);
      send_request(KIND_READ, 8'h00, 5'd31, 7'd127);
      send_request(KIND_READ, 8'h00, 5'd25, 7'd0);
      send_request(KIND_READ, 8'h00, 5'd0, 7'd80);
      // some puts carry all-ones position fields, which the block must ignore
      send_request(KIND_PUT, 8'h41, 5'd31, 7'd127);
      send_request(KIND_PUT, 8'h00, 5'd0, 7'd0);
      send_request(KIND_PUT, 8'hFF, 5'd31, 7'd127);
      send_request(KIND_PUT, CODE_CR, 5'd0, 7'd0);
      send_request(KIND_PUT, 8'h42, 5'd0, 7'd0);
      send_request(KIND_PUT, CODE_LF, 5'd0, 7'd0);
      // reads whose char_code is 0xFF or a control code, which a read must not use
      send_request(KIND_READ, 8'hFF, 5'd0, 7'd0);
      send_request(KIND_READ, CODE_LF, 5'd0, 7'd1);
      send_request(KIND_READ, CODE_CR, 5'd0, 7'd2);
      settle_console();

      // attribute extremes
      write_attribute(8'hFF);
      send_request(KIND_PUT, 8'h5A, 5'd17, 7'd99);
      send_request(KIND_READ, 8'h00, 5'd1, 7'd0);
      settle_console();
      write_attribute(8'h00);
      send_request(KIND_PUT, 8'h7E, 5'd0, 7'd0);
      send_request(KIND_READ, 8'h00, 5'd1, 7'd1);
      send_request(KIND_READ, 8'h00, 5'd1, 7'd2);
      settle_console();

      // Random phases, each on its own attribute.
      for (int p = 0; p < PHASES; p++) begin
         write_attribute(phase_attr[p]);
         repeat (PHASE_ITEMS) random_request();
         settle_console();
      end

      // The wait below outlasts a scroll, so it is long enough for a stray response
      // to show up.
      repeat (4 * COLUMNS) @(posedge clock);
      if (shadow.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

/* text_console_writer.f */
hw/rtl/tcw_pkg.sv
hw/rtl/text_console_writer.sv
hw/rtl/tcw_checker.sv
dv/text_console_writer_tb.sv
